>>> hw/rtl/tcsp_pkg.sv
// Shared types and constants for the text command session parser.
// Response codes, control characters, command words and the match flags struct.
// No dependencies.
`default_nettype none

package tcsp_pkg;

  localparam int BYTE_W     = 8;
  localparam int RESP_W     = 3;
  localparam int TIMER_W    = 16;
  localparam int PREFIX_LEN = 6;
  localparam int PFX_W      = 3;
  localparam int WORD_MAX   = 5;

  localparam logic [RESP_W-1:0] RESP_NONE     = 3'd0;
  localparam logic [RESP_W-1:0] RESP_OK_START = 3'd1;
  localparam logic [RESP_W-1:0] RESP_OK_STOP  = 3'd2;
  localparam logic [RESP_W-1:0] RESP_PONG_OFF = 3'd3;
  localparam logic [RESP_W-1:0] RESP_PONG_ON  = 3'd4;
  localparam logic [RESP_W-1:0] RESP_ERROR    = 3'd5;

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [TIMER_W-1:0] TIMER_MAX     = 16'hFFFF;

  // Words are stored first character in the lowest byte.
  typedef logic [WORD_MAX*BYTE_W-1:0] word_t;
  typedef logic [BYTE_W-1:0] prefix_t [PREFIX_LEN];

  localparam word_t WORD_START = {"T", "R", "A", "T", "S"};
  localparam word_t WORD_HELLO = {"O", "L", "L", "E", "H"};
  localparam word_t WORD_ON    = {8'h00, 8'h00, 8'h00, "N", "O"};
  localparam word_t WORD_STOP  = {8'h00, "P", "O", "T", "S"};
  localparam word_t WORD_OFF   = {8'h00, 8'h00, "F", "F", "O"};
  localparam word_t WORD_PING  = {8'h00, "G", "N", "I", "P"};

  typedef struct packed {
    logic start_cmd;
    logic stop_cmd;
    logic ping_cmd;
  } match_t;

  function automatic logic word_match(input prefix_t pfx, input logic [PFX_W-1:0] len,
                                      input word_t word, input logic [PFX_W-1:0] wlen);
    logic same;
    same = (len == wlen);
    for (int i = 0; i < WORD_MAX; i++) begin
      if ((PFX_W'(i) < wlen) && (pfx[i] != word[i*BYTE_W +: BYTE_W])) begin
        same = 1'b0;
      end
    end
    return same;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/text_command_session_parser.sv
// Text command session parser: line gathering, command decode, idle timeout.
// Depends on tcsp_pkg and tcsp_match.
// An input transaction passes through the input register and then the result register.
// Throughput: one item per cycle while m_axis_tready allows; the result register and input register stall together.
// Only the first six characters before the first zero byte are kept for matching.
// Reset (rst, synchronous): line empty, reporting off, idle count 0, timeout 5000.
`default_nettype none

module text_command_session_parser
  import tcsp_pkg::*;
#(
  parameter int LINE_CAPACITY = 32
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire  [7:0]         s_axis_tdata,   // [7:0] rx_byte
  input  wire  [0:0]         s_axis_tuser,   // [0] command (1 = tick)
  output logic               m_axis_tvalid,
  input  wire                m_axis_tready,
  output logic [7:0]         m_axis_tdata,   // [2:0] response, [3] reporting_on, [7:4] zero
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [TIMER_W-1:0] cfg_data
);

  localparam int LEN_W = $clog2(LINE_CAPACITY);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);

  logic              in_valid;
  logic              in_cmd;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;

  logic [LEN_W-1:0]   line_length, line_length_next;
  logic [PFX_W-1:0]   eff_len, eff_len_next;
  logic               zero_seen, zero_seen_next;
  prefix_t            prefix;
  logic               store_en;
  logic               reporting, reporting_next;
  logic [TIMER_W-1:0] idle_count, idle_count_next, idle_inc;
  logic [TIMER_W-1:0] idle_timeout;
  logic [RESP_W-1:0]  resp_next;
  logic [RESP_W-1:0]  resp;
  match_t             hit;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;
  assign m_axis_tdata  = {4'b0000, reporting, resp};

  tcsp_match u_match (
    .prefix (prefix),
    .eff_len(eff_len),
    .hit    (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd  <= s_axis_tuser[0];
      in_byte <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      idle_timeout <= cfg_data;
    end
  end

  assign idle_inc = (idle_count == TIMER_MAX) ? idle_count : idle_count + TIMER_W'(1);

  always_comb begin
    line_length_next = line_length;
    eff_len_next     = eff_len;
    zero_seen_next   = zero_seen;
    reporting_next   = reporting;
    idle_count_next  = idle_count;
    resp_next        = RESP_NONE;
    store_en         = 1'b0;
    if (in_cmd) begin
      idle_count_next = idle_inc;
      if (reporting && (idle_inc >= idle_timeout)) begin
        reporting_next = 1'b0;
      end
    end else if (in_byte == CHAR_CR) begin
      resp_next = RESP_NONE;
    end else if (in_byte == CHAR_LF) begin
      if (line_length != '0) begin
        if (hit.start_cmd) begin
          reporting_next  = 1'b1;
          idle_count_next = '0;
          resp_next       = RESP_OK_START;
        end else if (hit.stop_cmd) begin
          reporting_next  = 1'b0;
          idle_count_next = '0;
          resp_next       = RESP_OK_STOP;
        end else if (hit.ping_cmd) begin
          idle_count_next = '0;
          resp_next       = reporting ? RESP_PONG_ON : RESP_PONG_OFF;
        end else begin
          resp_next = RESP_ERROR;
        end
      end
      line_length_next = '0;
      eff_len_next     = '0;
      zero_seen_next   = 1'b0;
    end else if (line_length >= LEN_MAX) begin
      line_length_next = '0;
      eff_len_next     = '0;
      zero_seen_next   = 1'b0;
    end else begin
      store_en         = 1'b1;
      line_length_next = line_length + LEN_W'(1);
      if (!zero_seen) begin
        if (in_byte == '0) begin
          zero_seen_next = 1'b1;
        end else if (eff_len < PFX_W'(PREFIX_LEN)) begin
          eff_len_next = eff_len + PFX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length   <= '0;
      eff_len       <= '0;
      zero_seen     <= 1'b0;
      reporting     <= 1'b0;
      idle_count    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        line_length <= line_length_next;
        eff_len     <= eff_len_next;
        zero_seen   <= zero_seen_next;
        reporting   <= reporting_next;
        idle_count  <= idle_count_next;
        resp        <= resp_next;
      end
      if (advance) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PREFIX_LEN; i++) begin
      if (advance && store_en && (line_length == LEN_W'(i))) begin
        prefix[i] <= in_byte;
      end
    end
  end

  a_tick_no_resp: assert property (@(posedge clk) disable iff (rst)
    advance && in_cmd |=> m_axis_tdata[2:0] == RESP_NONE)
    else $error("tick produced a response");

  a_start_on: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (resp == RESP_OK_START) |-> reporting)
    else $error("start response with reporting off");

  a_stop_off: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (resp == RESP_OK_STOP) |-> !reporting)
    else $error("stop response with reporting on");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (line_length <= LEN_MAX) && (eff_len <= PFX_W'(PREFIX_LEN)))
    else $error("line length out of range");

endmodule

`default_nettype wire

>>> hw/rtl/tcsp_match.sv
// Exact command word matcher over the stored line prefix.
// Depends on tcsp_pkg.
`default_nettype none

module tcsp_match
  import tcsp_pkg::*;
(
  input  prefix_t          prefix,
  input  logic [PFX_W-1:0] eff_len,
  output match_t           hit
);

  always_comb begin
    hit.start_cmd = word_match(prefix, eff_len, WORD_START, PFX_W'(5)) ||
                    word_match(prefix, eff_len, WORD_HELLO, PFX_W'(5)) ||
                    word_match(prefix, eff_len, WORD_ON, PFX_W'(2));
    hit.stop_cmd  = word_match(prefix, eff_len, WORD_STOP, PFX_W'(4)) ||
                    word_match(prefix, eff_len, WORD_OFF, PFX_W'(3));
    hit.ping_cmd  = word_match(prefix, eff_len, WORD_PING, PFX_W'(4));
  end

endmodule

`default_nettype wire
